FILE: design/smalu_pkg.sv
// ----------------------------------------------------------------------------
// smalu_pkg: shared types for the SM83 ALU pipeline
// Operation codes, flag bundle and the payloads carried between stages.
// ----------------------------------------------------------------------------
package smalu_pkg;

  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 24;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_ADD16 = 5'd10,
    OP_ADDSP = 5'd11,
    OP_DAA   = 5'd12,
    OP_CPL   = 5'd13,
    OP_CCF   = 5'd14,
    OP_SCF   = 5'd15,
    OP_RLC   = 5'd16,
    OP_RRC   = 5'd17,
    OP_RL    = 5'd18,
    OP_RR    = 5'd19,
    OP_SLA   = 5'd20,
    OP_SRA   = 5'd21,
    OP_SRL   = 5'd22,
    OP_SWAP  = 5'd23,
    OP_BIT   = 5'd24,
    OP_RES   = 5'd25,
    OP_SET   = 5'd26,
    OP_RLCA  = 5'd27,
    OP_RRCA  = 5'd28,
    OP_RLA   = 5'd29,
    OP_RRA   = 5'd30
  } op_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // unpacked input word
  typedef struct packed {
    op_t         op;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [2:0]  idx;
    flags_t      fl;
  } req_t;

  // after decode stage
  typedef struct packed {
    op_t         op;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [2:0]  idx;
    flags_t      fl;
    logic        cin;     // carry into 8-bit add/sub (adc/sbc only)
    logic [15:0] sp_off;  // sign-extended offset for addsp
  } dec_t;

  // after arithmetic stage
  typedef struct packed {
    op_t         op;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [2:0]  idx;
    flags_t      fl;
    logic [15:0] ar_res;
    flags_t      ar_fl;
  } ari_t;

  typedef struct packed {
    logic [15:0] res;
    flags_t      fl;
  } rsp_t;

endpackage

FILE: design/smalu_dec.sv
// ----------------------------------------------------------------------------
// smalu_dec: decode stage
// Registers the incoming word, gates the carry-in and extends the SP offset.
// ----------------------------------------------------------------------------
module smalu_dec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  smalu_pkg::req_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output smalu_pkg::dec_t  out_data
);
  import smalu_pkg::*;

  logic valid_r;
  dec_t data_r;
  dec_t data_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt.op     = in_data.op;
    data_nxt.wa     = in_data.wa;
    data_nxt.wb     = in_data.wb;
    data_nxt.idx    = in_data.idx;
    data_nxt.fl     = in_data.fl;
    data_nxt.cin    = in_data.fl.c && (in_data.op == OP_ADC || in_data.op == OP_SBC);
    data_nxt.sp_off = {{8{in_data.wb[7]}}, in_data.wb[7:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: design/smalu_ari.sv
// ----------------------------------------------------------------------------
// smalu_ari: arithmetic stage
// Adders and subtractors: 8-bit add/sub/cp, inc/dec, add16, addsp and DAA.
// ----------------------------------------------------------------------------
module smalu_ari (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  smalu_pkg::dec_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output smalu_pkg::ari_t  out_data
);
  import smalu_pkg::*;

  logic valid_r;
  ari_t data_r;
  ari_t data_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    logic [7:0]  a;
    logic [7:0]  b;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  dif9;
    logic [4:0]  hdif5;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] sp16;
    logic [4:0]  sph5;
    logic [8:0]  spc9;
    logic        daa_hi;
    logic        daa_lo;
    logic [7:0]  daa_adj;
    logic [7:0]  daa8;
    a       = in_data.wa[7:0];
    b       = in_data.wb[7:0];
    sum9    = {1'b0, a} + {1'b0, b} + {8'd0, in_data.cin};
    hsum5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, in_data.cin};
    dif9    = {1'b0, a} - {1'b0, b} - {8'd0, in_data.cin};
    hdif5   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, in_data.cin};
    inc8    = a + 8'd1;
    dec8    = a - 8'd1;
    sum17   = {1'b0, in_data.wa} + {1'b0, in_data.wb};
    sum13   = {1'b0, in_data.wa[11:0]} + {1'b0, in_data.wb[11:0]};
    sp16    = in_data.wa + in_data.sp_off;
    sph5    = {1'b0, in_data.wa[3:0]} + {1'b0, b[3:0]};
    spc9    = {1'b0, in_data.wa[7:0]} + {1'b0, b};
    // DAA: after a subtract only the recorded carries drive the correction
    daa_hi  = in_data.fl.n ? in_data.fl.c : (in_data.fl.c || (a > 8'h99));
    daa_lo  = in_data.fl.n ? in_data.fl.h : (in_data.fl.h || (a[3:0] > 4'd9));
    daa_adj = {1'b0, daa_hi, daa_hi, 1'b0, 1'b0, daa_lo, daa_lo, 1'b0};
    daa8    = in_data.fl.n ? (a - daa_adj) : (a + daa_adj);

    data_nxt.op  = in_data.op;
    data_nxt.a   = a;
    data_nxt.b   = b;
    data_nxt.idx = in_data.idx;
    data_nxt.fl  = in_data.fl;
    data_nxt.ar_res = 16'd0;
    data_nxt.ar_fl  = in_data.fl;

    case (in_data.op)
      OP_ADD, OP_ADC: begin
        data_nxt.ar_res = {8'd0, sum9[7:0]};
        data_nxt.ar_fl  = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        data_nxt.ar_res = (in_data.op == OP_CP) ? {8'd0, a} : {8'd0, dif9[7:0]};
        data_nxt.ar_fl  = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
      end
      OP_INC: begin
        data_nxt.ar_res = {8'd0, inc8};
        data_nxt.ar_fl  = '{z: (inc8 == 8'd0), n: 1'b0, h: (inc8[3:0] == 4'h0),
                            c: in_data.fl.c};
      end
      OP_DEC: begin
        data_nxt.ar_res = {8'd0, dec8};
        data_nxt.ar_fl  = '{z: (dec8 == 8'd0), n: 1'b1, h: (dec8[3:0] == 4'hF),
                            c: in_data.fl.c};
      end
      OP_ADD16: begin
        data_nxt.ar_res = sum17[15:0];
        data_nxt.ar_fl  = '{z: in_data.fl.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      end
      OP_ADDSP: begin
        data_nxt.ar_res = sp16;
        data_nxt.ar_fl  = '{z: 1'b0, n: 1'b0, h: sph5[4], c: spc9[8]};
      end
      OP_DAA: begin
        data_nxt.ar_res = {8'd0, daa8};
        data_nxt.ar_fl  = '{z: (daa8 == 8'd0), n: in_data.fl.n, h: 1'b0, c: daa_hi};
      end
      default: begin
        data_nxt.ar_res = 16'd0;
        data_nxt.ar_fl  = in_data.fl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: design/smalu_wb.sv
// ----------------------------------------------------------------------------
// smalu_wb: logic/shift stage and result register
// Logic ops, rotates, shifts, bit ops and final result/flag selection.
// ----------------------------------------------------------------------------
module smalu_wb (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  smalu_pkg::ari_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output smalu_pkg::rsp_t  out_data
);
  import smalu_pkg::*;

  logic valid_r;
  rsp_t data_r;
  rsp_t data_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r8;
    logic [7:0] mask;
    logic       sh_out;
    flags_t     fi;
    a    = in_data.a;
    b    = in_data.b;
    fi   = in_data.fl;
    mask = 8'd1 << in_data.idx;
    r8   = 8'd0;
    sh_out = 1'b0;
    data_nxt.res = 16'd0;
    data_nxt.fl  = fi;

    case (in_data.op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP, OP_INC, OP_DEC,
      OP_ADD16, OP_ADDSP, OP_DAA: begin
        data_nxt.res = in_data.ar_res;
        data_nxt.fl  = in_data.ar_fl;
      end
      OP_AND, OP_XOR, OP_OR, OP_SWAP: begin
        case (in_data.op)
          OP_AND:  r8 = a & b;
          OP_XOR:  r8 = a ^ b;
          OP_OR:   r8 = a | b;
          default: r8 = {a[3:0], a[7:4]};
        endcase
        data_nxt.res = {8'd0, r8};
        data_nxt.fl  = '{z: (r8 == 8'd0), n: 1'b0, h: (in_data.op == OP_AND), c: 1'b0};
      end
      OP_CPL: begin
        data_nxt.res = {8'd0, ~a};
        data_nxt.fl  = '{z: fi.z, n: 1'b1, h: 1'b1, c: fi.c};
      end
      OP_CCF, OP_SCF: begin
        data_nxt.res = {8'd0, a};
        data_nxt.fl  = '{z: fi.z, n: 1'b0, h: 1'b0, c: (in_data.op == OP_SCF) || !fi.c};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL,
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        case (in_data.op)
          OP_RLC, OP_RLCA: begin r8 = {a[6:0], a[7]}; sh_out = a[7]; end
          OP_RRC, OP_RRCA: begin r8 = {a[0], a[7:1]}; sh_out = a[0]; end
          OP_RL, OP_RLA:   begin r8 = {a[6:0], fi.c}; sh_out = a[7]; end
          OP_RR, OP_RRA:   begin r8 = {fi.c, a[7:1]}; sh_out = a[0]; end
          OP_SLA:          begin r8 = {a[6:0], 1'b0}; sh_out = a[7]; end
          OP_SRA:          begin r8 = {a[7], a[7:1]}; sh_out = a[0]; end
          default:         begin r8 = {1'b0, a[7:1]}; sh_out = a[0]; end
        endcase
        data_nxt.res = {8'd0, r8};
        // accumulator forms always clear Z
        data_nxt.fl  = '{z: (r8 == 8'd0) && !(in_data.op inside {[OP_RLCA:OP_RRA]}),
                         n: 1'b0, h: 1'b0, c: sh_out};
      end
      OP_BIT: begin
        data_nxt.res = {8'd0, a};
        data_nxt.fl  = '{z: ((a & mask) == 8'd0), n: 1'b0, h: 1'b1, c: fi.c};
      end
      OP_RES: begin
        data_nxt.res = {8'd0, a & ~mask};
      end
      OP_SET: begin
        data_nxt.res = {8'd0, a | mask};
      end
      default: begin
        data_nxt.res = 16'd0;
        data_nxt.fl  = fi;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: design/sm83_alu_with_flags.sv
// An accepted word passes the decode, arithmetic and logic/select registers.
// Throughput: one word per cycle; each of the three stages holds one word
//   and advances whenever the stage after it is empty or draining.
// Reset: rst_n (synchronous, active low) clears all stage valid bits;
//   data registers are not reset.
// ----------------------------------------------------------------------------
// sm83_alu_with_flags: pipelined SM83 ALU with Z/N/H/C flags
// Decode, arithmetic and logic/select stages, with a registered output.
// ----------------------------------------------------------------------------
module sm83_alu_with_flags (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // req_type[4:0], operand_a[20:5], operand_b[36:21], bit_index[39:37],
  // zero_in[40], subtract_in[41], half_in[42], carry_in[43], zero pad
  input  logic [smalu_pkg::InTdataW-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // result[15:0], zero_out[16], subtract_out[17], half_out[18],
  // carry_out[19], zero pad
  output logic [smalu_pkg::OutTdataW-1:0]   out_tdata
);
  import smalu_pkg::*;

  req_t req;
  dec_t dec_data;
  ari_t ari_data;
  rsp_t rsp_data;
  logic dec_valid, dec_ready;
  logic ari_valid, ari_ready;

  assign req.op   = op_t'(in_tdata[4:0]);
  assign req.wa   = in_tdata[20:5];
  assign req.wb   = in_tdata[36:21];
  assign req.idx  = in_tdata[39:37];
  assign req.fl.z = in_tdata[40];
  assign req.fl.n = in_tdata[41];
  assign req.fl.h = in_tdata[42];
  assign req.fl.c = in_tdata[43];

  smalu_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (req),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  smalu_ari u_ari (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (ari_valid),
    .out_ready (ari_ready),
    .out_data  (ari_data)
  );

  smalu_wb u_wb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ari_valid),
    .in_ready  (ari_ready),
    .in_data   (ari_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (rsp_data)
  );

  assign out_tdata = {4'd0, rsp_data.fl.c, rsp_data.fl.h, rsp_data.fl.n, rsp_data.fl.z,
                      rsp_data.res};

endmodule

FILE: test/sm83_alu_flag_checker.sv
// ----------------------------------------------------------------------------
// sm83_alu_flag_checker: result predictor and scoreboard for the SM83 ALU
// Watches both stream channels. Each accepted input word is evaluated into
// the expected result and flags, and each result word is matched in order.
// ----------------------------------------------------------------------------
module sm83_alu_flag_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [smalu_pkg::InTdataW-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [smalu_pkg::OutTdataW-1:0] out_tdata,
  output int unsigned                     mismatches,
  output int unsigned                     rsp_pending
);
  import smalu_pkg::*;

  typedef struct packed {
    logic [InTdataW-1:0] req;
    rsp_t                rsp;
  } alu_txn_t;

  alu_txn_t    txn_q[$];
  int unsigned bad_n = 0;

  function automatic rsp_t alu_eval(input logic [InTdataW-1:0] w);
    logic [4:0]  op;
    logic [15:0] wa, wb, off;
    logic [2:0]  idx;
    logic [7:0]  a, b, r8, dw;
    logic        ci, cin, co, rot;
    logic [4:0]  s5;
    logic [8:0]  s9;
    logic [12:0] s13;
    logic [16:0] s17;
    flags_t      f;
    rsp_t        o;
    op  = w[4:0];
    wa  = w[20:5];
    wb  = w[36:21];
    idx = w[39:37];
    f.z = w[40];
    f.n = w[41];
    f.h = w[42];
    f.c = w[43];
    ci  = f.c;
    a   = wa[7:0];
    b   = wb[7:0];
    r8  = 8'h00;
    co  = 1'b0;
    rot = 1'b0;
    o.res = 16'h0000;
    case (op)
      OP_ADD, OP_ADC: begin
        cin = (op == OP_ADC) ? ci : 1'b0;
        s9  = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
        o.res = {8'h00, s9[7:0]};
        f.z = (s9[7:0] == 8'h00);
        f.n = 1'b0;
        f.h = s5[4];
        f.c = s9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cin = (op == OP_SBC) ? ci : 1'b0;
        // borrow shows up as the sign bit of the widened difference
        s9  = {1'b0, a} - {1'b0, b} - {8'h00, cin};
        s5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin};
        o.res = (op == OP_CP) ? {8'h00, a} : {8'h00, s9[7:0]};
        f.z = (s9[7:0] == 8'h00);
        f.n = 1'b1;
        f.h = s5[4];
        f.c = s9[8];
      end
      OP_AND, OP_XOR, OP_OR, OP_SWAP: begin
        case (op)
          OP_AND:  r8 = a & b;
          OP_XOR:  r8 = a ^ b;
          OP_OR:   r8 = a | b;
          default: r8 = {a[3:0], a[7:4]};
        endcase
        o.res = {8'h00, r8};
        f.z = (r8 == 8'h00);
        f.n = 1'b0;
        f.h = (op == OP_AND);
        f.c = 1'b0;
      end
      OP_INC: begin
        r8 = a + 8'h01;
        o.res = {8'h00, r8};
        f.z = (r8 == 8'h00);
        f.n = 1'b0;
        f.h = (r8[3:0] == 4'h0);
      end
      OP_DEC: begin
        r8 = a - 8'h01;
        o.res = {8'h00, r8};
        f.z = (r8 == 8'h00);
        f.n = 1'b1;
        f.h = (r8[3:0] == 4'hF);
      end
      OP_ADD16: begin
        s17 = {1'b0, wa} + {1'b0, wb};
        s13 = {1'b0, wa[11:0]} + {1'b0, wb[11:0]};
        o.res = s17[15:0];
        f.n = 1'b0;
        f.h = s13[12];
        f.c = s17[16];
      end
      OP_ADDSP: begin
        // H and C come from the unsigned low-byte add, not the signed one
        off = {{8{b[7]}}, b};
        o.res = wa + off;
        s5  = {1'b0, wa[3:0]} + {1'b0, b[3:0]};
        s9  = {1'b0, wa[7:0]} + {1'b0, b};
        f.z = 1'b0;
        f.n = 1'b0;
        f.h = s5[4];
        f.c = s9[8];
      end
      OP_DAA: begin
        dw = a;
        if (!f.n) begin
          if (ci || a > 8'h99) begin
            dw  = dw + 8'h60;
            f.c = 1'b1;
          end
          if (f.h || a[3:0] > 4'd9) dw = dw + 8'h06;
        end else begin
          if (ci) dw = dw - 8'h60;
          if (f.h) dw = dw - 8'h06;
        end
        o.res = {8'h00, dw};
        f.z = (dw == 8'h00);
        f.h = 1'b0;
      end
      OP_CPL: begin
        o.res = {8'h00, ~a};
        f.n = 1'b1;
        f.h = 1'b1;
      end
      OP_CCF, OP_SCF: begin
        o.res = {8'h00, a};
        f.n = 1'b0;
        f.h = 1'b0;
        f.c = (op == OP_SCF) ? 1'b1 : ~ci;
      end
      OP_RLC, OP_RLCA: begin r8 = {a[6:0], a[7]}; co = a[7]; rot = 1'b1; end
      OP_RRC, OP_RRCA: begin r8 = {a[0], a[7:1]}; co = a[0]; rot = 1'b1; end
      OP_RL,  OP_RLA:  begin r8 = {a[6:0], ci};   co = a[7]; rot = 1'b1; end
      OP_RR,  OP_RRA:  begin r8 = {ci, a[7:1]};   co = a[0]; rot = 1'b1; end
      OP_SLA:          begin r8 = {a[6:0], 1'b0}; co = a[7]; rot = 1'b1; end
      OP_SRA:          begin r8 = {a[7], a[7:1]}; co = a[0]; rot = 1'b1; end
      OP_SRL:          begin r8 = {1'b0, a[7:1]}; co = a[0]; rot = 1'b1; end
      OP_BIT: begin
        o.res = {8'h00, a};
        f.z = ~a[idx];
        f.n = 1'b0;
        f.h = 1'b1;
      end
      OP_RES: o.res = {8'h00, a & ~(8'h01 << idx)};
      OP_SET: o.res = {8'h00, a | (8'h01 << idx)};
      default: o.res = 16'h0000;  // unused code: zero result, flags pass through
    endcase
    if (rot) begin
      o.res = {8'h00, r8};
      // accumulator forms never set Z
      f.z = (r8 == 8'h00) && (op < OP_RLCA);
      f.n = 1'b0;
      f.h = 1'b0;
      f.c = co;
    end
    o.fl = f;
    return o;
  endfunction

  always @(posedge clk) begin : scoreboard
    alu_txn_t want;
    rsp_t     got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.res = out_tdata[15:0];
        got.fl  = {out_tdata[16], out_tdata[17], out_tdata[18], out_tdata[19]};
        if (txn_q.size() == 0) begin
          bad_n++;
          if (bad_n <= 10)
            $display("unexpected result word: res=%h znhc=%b", got.res, got.fl);
        end else begin
          want = txn_q.pop_front();
          if (got.res !== want.rsp.res || got.fl.z !== want.rsp.fl.z ||
              got.fl.n !== want.rsp.fl.n || got.fl.h !== want.rsp.fl.h ||
              got.fl.c !== want.rsp.fl.c) begin
            bad_n++;
            if (bad_n <= 10)
              $display("mismatch op=%0d a=%h b=%h bit=%0d znhc_in=%b: %s=%h znhc=%b, %s=%h znhc=%b",
                       want.req[4:0], want.req[20:5], want.req[36:21], want.req[39:37],
                       {want.req[40], want.req[41], want.req[42], want.req[43]},
                       "exp res", want.rsp.res, want.rsp.fl, "got res", got.res, got.fl);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want.req = in_tdata;
        want.rsp = alu_eval(in_tdata);
        txn_q.push_back(want);
      end
    end
    mismatches  <= bad_n;
    rsp_pending <= txn_q.size();
  end

endmodule

FILE: test/sm83_alu_with_flags_test.sv
// ----------------------------------------------------------------------------
// sm83_alu_with_flags_test: stream-level test of the pipelined SM83 ALU
// Sends every operation with corner operands, then random words in bursts
// while the result side stalls on its own pattern; the checker scores results.
// ----------------------------------------------------------------------------
module sm83_alu_with_flags_test;
  import smalu_pkg::*;

  localparam logic [4:0]  OpUnused   = 5'd31;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandWords  = 1400;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OutTdataW-1:0] out_tdata;
  int unsigned          mismatches;
  int unsigned          rsp_pending;
  int unsigned          burst_left = 0;
  int unsigned          stall_cycles = 0;

  sm83_alu_with_flags dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sm83_alu_flag_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .rsp_pending (rsp_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [InTdataW-1:0] pack_req(input logic [4:0] op,
                                                   input logic [15:0] a,
                                                   input logic [15:0] b,
                                                   input logic [2:0] idx,
                                                   input flags_t fl);
    return {4'h0, fl.c, fl.h, fl.n, fl.z, idx, b, a, op};
  endfunction

  // mostly random operands, with a fair share of boundary values
  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 9))
        0: v = 16'h0000;
        1: v = 16'h0001;
        2: v = 16'h000F;
        3: v = 16'h007F;
        4: v = 16'h0080;
        5: v = 16'h00FF;
        6: v = 16'h0FFF;
        7: v = 16'h1000;
        8: v = 16'hFF00;
        default: v = 16'hFFFF;
      endcase
    end
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_word(input logic [InTdataW-1:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // result-side backpressure, with two long hold-offs to fill the pipe
  initial begin : rx_side
    int unsigned mode, left, hold, ticks;
    out_tready = 1'b0;
    mode  = 0;
    left  = 0;
    hold  = 0;
    ticks = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      ticks++;
      if (ticks == 300 || ticks == 2500) hold = 80;
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 120);
      end
      left--;
      if (hold != 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : tx_side
    logic [15:0] corner_vals [0:3];
    logic [4:0]  op;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    corner_vals[0] = 16'h0000;
    corner_vals[1] = 16'hFFFF;
    corner_vals[2] = 16'h0F0F;
    corner_vals[3] = 16'h8001;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every code once, including the unused one, with rotating corners
    for (int i = 0; i <= OpUnused; i++) begin
      push_word(pack_req(i[4:0], corner_vals[i % 4], corner_vals[(i + 1) % 4],
                         i[2:0], flags_t'(i[3:0])));
    end
    push_word(pack_req(OP_DAA,   16'h009A, 16'h0000, 3'd0, '{1'b0, 1'b0, 1'b0, 1'b0}));
    push_word(pack_req(OP_DAA,   16'h0000, 16'h0000, 3'd0, '{1'b0, 1'b1, 1'b1, 1'b1}));
    push_word(pack_req(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, '{1'b1, 1'b1, 1'b1, 1'b0}));
    push_word(pack_req(OP_ADDSP, 16'h00FF, 16'h00FF, 3'd0, '{1'b1, 1'b1, 1'b0, 1'b0}));
    push_word(pack_req(OP_CP,    16'h0042, 16'h0042, 3'd0, '{1'b0, 1'b0, 1'b0, 1'b0}));
    push_word(pack_req(OP_SBC,   16'h0010, 16'h000F, 3'd0, '{1'b0, 1'b0, 1'b0, 1'b1}));

    repeat (RandWords) begin
      op = 5'($urandom_range(0, 31));
      push_word(pack_req(op, pick_operand(), pick_operand(), 3'($urandom_range(0, 7)),
                         flags_t'($urandom_range(0, 15))));
    end
    in_tvalid <= 1'b0;

    while (rsp_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && rsp_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
